/* hw/rtl/tsfp_pkg.sv */
package tsfp_pkg;

    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned IndexWidth = 14;
    localparam int unsigned LimitWidth = 15;
    localparam int unsigned WordWidth  = 32;

    localparam logic [LimitWidth-1:0] LimitReset = 15'd16384;

    typedef enum logic [1:0] {
        PH_HDR_LO  = 2'd0,
        PH_HDR_HI  = 2'd1,
        PH_VALUE   = 2'd2,
        PH_TRAILER = 2'd3
    } tsfp_phase_t;

    typedef enum logic [1:0] {
        FMT_FLOAT = 2'd0,
        FMT_INT8  = 2'd1,
        FMT_INT16 = 2'd2,
        FMT_INT32 = 2'd3
    } tsfp_format_t;

    typedef enum logic {
        KIND_FEATURE = 1'b0,
        KIND_END     = 1'b1
    } tsfp_kind_t;

    typedef struct packed {
        logic                  valid;
        logic [ByteWidth-1:0]  data;
    } tsfp_byte_t;

    // packed from the top bit down, so feature_index lands in the lowest bits
    typedef struct packed {
        logic [7:0]                   second_factor;
        logic [7:0]                   first_factor;
        logic signed [15:0]           score;
        logic signed [WordWidth-1:0]  value_word;
        logic [1:0]                   value_format;
        logic [IndexWidth-1:0]        feature_index;
    } tsfp_result_t;

    localparam int unsigned ResultWidth = $bits(tsfp_result_t);

    function automatic logic [1:0] last_pos(input logic [1:0] fmt);
        logic [1:0] pos;
        unique case (fmt)
            FMT_INT8:  pos = 2'd0;
            FMT_INT16: pos = 2'd1;
            default:   pos = 2'd3;
        endcase
        return pos;
    endfunction

    function automatic logic [WordWidth-1:0] extend_value(input logic [1:0] fmt,
                                                         input logic [WordWidth-1:0] raw);
        logic [WordWidth-1:0] w;
        unique case (fmt)
            FMT_INT8:  w = {{24{raw[7]}}, raw[7:0]};
            FMT_INT16: w = {{16{raw[15]}}, raw[15:0]};
            default:   w = raw;
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/tsfp_in_stage.sv */
module tsfp_in_stage
    import tsfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ByteWidth-1:0] in_data,
    output tsfp_byte_t           held,
    input  logic                 take
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [ByteWidth-1:0] data_reg;
    logic [ByteWidth-1:0] data_next;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
            data_next  = in_data;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign held.valid = valid_reg;
    assign held.data  = data_reg;

endmodule

/* hw/rtl/tsfp_parse.sv */
module tsfp_parse
    import tsfp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [LimitWidth-1:0] cfg_data,
    input  tsfp_byte_t            held,
    output logic                  take,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tsfp_result_t          out_result,
    output tsfp_kind_t            out_kind
);

    tsfp_phase_t           phase_reg;
    tsfp_phase_t           phase_next;
    logic [LimitWidth-1:0] limit_reg;
    logic [ByteWidth-1:0]  header_low_reg;
    logic [ByteWidth-1:0]  header_low_next;
    logic [1:0]            format_reg;
    logic [1:0]            format_next;
    logic [IndexWidth-1:0] index_reg;
    logic [IndexWidth-1:0] index_next;
    logic [WordWidth-1:0]  assembly_reg;
    logic [WordWidth-1:0]  assembly_next;
    logic [1:0]            pos_reg;
    logic [1:0]            pos_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    tsfp_result_t          result_reg;
    tsfp_result_t          result_next;
    tsfp_kind_t            kind_reg;
    tsfp_kind_t            kind_next;

    logic                  emit;
    logic [WordWidth-1:0]  word_cur;
    logic [IndexWidth-1:0] hdr_index;

    assign take      = held.valid && (!out_valid_reg || out_ready);
    assign hdr_index = {held.data[5:0], header_low_reg};

    always_comb
    begin
        word_cur = assembly_reg;
        word_cur[{pos_reg, 3'b000} +: ByteWidth] = held.data;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        header_low_next = header_low_reg;
        format_next     = format_reg;
        index_next      = index_reg;
        assembly_next   = assembly_reg;
        pos_next        = pos_reg;
        emit            = 1'b0;
        result_next     = result_reg;
        kind_next       = kind_reg;
        if (take)
        begin
            unique case (phase_reg)
                PH_HDR_LO:
                begin
                    header_low_next = held.data;
                    phase_next      = PH_HDR_HI;
                end
                PH_HDR_HI:
                begin
                    format_next   = held.data[7:6];
                    index_next    = hdr_index;
                    assembly_next = '0;
                    pos_next      = 2'd0;
                    if ({1'b0, hdr_index} >= limit_reg)
                    begin
                        phase_next = PH_TRAILER;
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    assembly_next = word_cur;
                    pos_next      = pos_reg + 2'd1;
                    if (pos_reg == last_pos(format_reg))
                    begin
                        emit                       = 1'b1;
                        kind_next                  = KIND_FEATURE;
                        result_next                = '0;
                        result_next.feature_index  = index_reg;
                        result_next.value_format   = format_reg;
                        result_next.value_word     = extend_value(format_reg, word_cur);
                        phase_next                 = PH_HDR_LO;
                        assembly_next              = '0;
                        pos_next                   = 2'd0;
                    end
                end
                PH_TRAILER:
                begin
                    assembly_next = word_cur;
                    pos_next      = pos_reg + 2'd1;
                    if (pos_reg == 2'd3)
                    begin
                        emit                      = 1'b1;
                        kind_next                 = KIND_END;
                        result_next               = '0;
                        result_next.score         = word_cur[15:0];
                        result_next.first_factor  = word_cur[23:16];
                        result_next.second_factor = word_cur[31:24];
                        phase_next                = PH_HDR_LO;
                        assembly_next             = '0;
                        pos_next                  = 2'd0;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR_LO;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR_LO;
            limit_reg      <= LimitReset;
            header_low_reg <= '0;
            format_reg     <= '0;
            index_reg      <= '0;
            assembly_reg   <= '0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            header_low_reg <= header_low_next;
            format_reg     <= format_next;
            index_reg      <= index_next;
            assembly_reg   <= assembly_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        kind_reg   <= kind_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;
    assign out_kind   = kind_reg;

    a_result_from_take: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(take))
        else $error("result appeared without a consumed byte");

    a_low_then_high: assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == PH_HDR_LO) |=> (phase_reg == PH_HDR_HI))
        else $error("header low byte not followed by high byte phase");

    a_emit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (phase_reg == PH_HDR_LO && assembly_reg == '0))
        else $error("record state not cleared after a result");

    a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HDR_LO || phase_reg == PH_HDR_HI) |-> (pos_reg == 2'd0))
        else $error("byte position not zero in header phase");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !take)
        else $error("byte consumed while result stalled");

endmodule

/* hw/rtl/tagged_sparse_feature_parser.sv */
// Tagged sparse feature parser.
// s_axis carries one byte of a little-endian record stream per transaction.
// Each record is a run of 16-bit headers (2-bit format tag, 14-bit index); an
// index below feature_limit is followed by a value of 1, 2 or 4 bytes and
// produces a feature result, an index at or above it is followed by four
// trailer bytes and produces an end-of-record result.
// m_axis carries one result per transaction; tuser is the kind (0 feature,
// 1 end of record), tdata the payload fields.
// cfg writes feature_limit; write it only while the stream is idle.
// Throughput: one byte per cycle while m_axis does not stall. Each byte passes
// an input register and then the result register before its result appears.
// When m_axis stalls, the pending result holds and the input register takes at
// most one more byte; s_axis_tready then drops until the result is taken.
// Reset: empty pipeline, parser waits for a header low byte, feature_limit is
// 16384 (no header ends a record until written lower).
module tagged_sparse_feature_parser
    import tsfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [ByteWidth-1:0]   s_axis_tdata,   // byte_value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // feature_index[13:0], value_format[15:14], value_word[47:16],
    // score[63:48], first_factor[71:64], second_factor[79:72]
    output logic [ResultWidth-1:0] m_axis_tdata,
    output logic [0:0]             m_axis_tuser,   // out_kind
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LimitWidth-1:0]  cfg_data        // feature_limit
);

    tsfp_byte_t   held;
    logic         take;
    tsfp_result_t result;
    tsfp_kind_t   kind;

    assign cfg_ready = 1'b1;

    tsfp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .held     (held),
        .take     (take)
    );

    tsfp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .held       (held),
        .take       (take),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result),
        .out_kind   (kind)
    );

    assign m_axis_tdata = result;
    assign m_axis_tuser = kind;

endmodule
